>>> src/assert_macros.svh
// Assertion macros shared by the RTC modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rtc_pkg.sv
// Package for the RTC: item types, register offsets, operation codes,
// prescaler sizing and the identification word table. No dependencies.
package rtc_pkg;

    // Reference clock ticks per second and prescaler width
    localparam int unsigned TICKS_PER_SECOND = 32768;
    localparam int unsigned PRESCALE_W       = $clog2(TICKS_PER_SECOND + 1);

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register offsets
    localparam logic [11:0] OFS_DATA    = 12'h000;
    localparam logic [11:0] OFS_MATCH   = 12'h004;
    localparam logic [11:0] OFS_LOAD    = 12'h008;
    localparam logic [11:0] OFS_CTRL    = 12'h00c;
    localparam logic [11:0] OFS_MASK    = 12'h010;
    localparam logic [11:0] OFS_RAW     = 12'h014;
    localparam logic [11:0] OFS_MASKED  = 12'h018;
    localparam logic [11:0] OFS_CLEAR   = 12'h01c;
    localparam logic [11:0] OFS_ID_BASE = 12'hfe0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic [31:0] wall_clock_seconds;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
    } out_item_t;

    // Identification words at 0xfe0..0xffc, indexed by offset bits [4:2]
    function automatic logic [31:0] id_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'h31;
            3'd1:    w = 32'h10;
            3'd2:    w = 32'h04;
            3'd3:    w = 32'h00;
            3'd4:    w = 32'h0d;
            3'd5:    w = 32'hf0;
            3'd6:    w = 32'h05;
            3'd7:    w = 32'hb1;
            default: w = 32'h00;
        endcase
        return w;
    endfunction

endpackage

>>> src/rtc_in_if.sv
// Input channel of the RTC: valid/ready handshake with one bus or tick item.
// Depends on rtc_pkg.
interface rtc_in_if;
    logic             valid;
    logic             ready;
    rtc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/rtc_out_if.sv
// Result channel of the RTC: valid/ready handshake with one result item.
// Depends on rtc_pkg.
interface rtc_out_if;
    logic              valid;
    logic              ready;
    rtc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/rtc_regs.sv
// RTC register file: prescaler, seconds counter, alarm and read mux.
// Depends on rtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  rtc_pkg::in_item_t  item,
    output rtc_pkg::out_item_t result
);

    localparam int unsigned PW = rtc_pkg::PRESCALE_W;

    logic          enabled_reg,  enabled_next;
    logic          irq_mask_reg, irq_mask_next;
    logic          raw_status_reg, raw_status_next;
    logic          alarm_armed_reg, alarm_armed_next;
    logic [31:0]   seconds_reg,  seconds_next;
    logic [31:0]   load_reg,     load_next;
    logic [31:0]   match_reg,    match_next;
    logic [PW-1:0] prescale_reg, prescale_next;

    logic [PW-1:0] prescale_inc;
    logic [31:0]   seconds_inc;
    logic [31:0]   rdata;

    assign prescale_inc = prescale_reg + PW'(1);
    assign seconds_inc  = seconds_reg + 32'd1;

    // Read mux
    always_comb
    begin
        rdata = 32'd0;
        case (item.reg_offset)
            rtc_pkg::OFS_DATA:   rdata = enabled_reg ? seconds_reg : 32'd0;
            rtc_pkg::OFS_MATCH:  rdata = match_reg;
            rtc_pkg::OFS_LOAD:   rdata = load_reg;
            rtc_pkg::OFS_CTRL:   rdata = {31'd0, enabled_reg};
            rtc_pkg::OFS_MASK:   rdata = {31'd0, irq_mask_reg};
            rtc_pkg::OFS_RAW:    rdata = {31'd0, raw_status_reg};
            rtc_pkg::OFS_MASKED: rdata = {31'd0, raw_status_reg & irq_mask_reg};
            default:
            begin
                if (item.reg_offset >= rtc_pkg::OFS_ID_BASE && item.reg_offset[1:0] == 2'b00)
                    rdata = rtc_pkg::id_word(item.reg_offset[4:2]);
            end
        endcase
    end

    // Next state for writes and ticks
    always_comb
    begin
        enabled_next     = enabled_reg;
        irq_mask_next    = irq_mask_reg;
        raw_status_next  = raw_status_reg;
        alarm_armed_next = alarm_armed_reg;
        seconds_next     = seconds_reg;
        load_next        = load_reg;
        match_next       = match_reg;
        prescale_next    = prescale_reg;
        case (item.operation)
            rtc_pkg::OP_WRITE:
            begin
                case (item.reg_offset)
                    rtc_pkg::OFS_MATCH:
                    begin
                        match_next       = item.write_data;
                        alarm_armed_next = item.write_data > load_reg;
                    end
                    rtc_pkg::OFS_LOAD:
                    begin
                        load_next     = item.write_data;
                        seconds_next  = item.write_data;
                        prescale_next = '0;
                    end
                    rtc_pkg::OFS_CTRL:
                    begin
                        // enable rising loads wall time, falling clears everything
                        if (item.write_data[0] && !enabled_reg)
                        begin
                            enabled_next  = 1'b1;
                            seconds_next  = item.wall_clock_seconds;
                            load_next     = item.wall_clock_seconds;
                            prescale_next = '0;
                        end
                        else if (!item.write_data[0] && enabled_reg)
                        begin
                            enabled_next     = 1'b0;
                            raw_status_next  = 1'b0;
                            irq_mask_next    = 1'b0;
                            alarm_armed_next = 1'b0;
                            match_next       = 32'd0;
                            load_next        = 32'd0;
                            seconds_next     = 32'd0;
                            prescale_next    = '0;
                        end
                    end
                    rtc_pkg::OFS_MASK:  irq_mask_next = item.write_data[0];
                    rtc_pkg::OFS_CLEAR:
                    begin
                        if (item.write_data[0])
                            raw_status_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            rtc_pkg::OP_TICK:
            begin
                if (enabled_reg)
                begin
                    if (32'(prescale_inc) >= rtc_pkg::TICKS_PER_SECOND)
                    begin
                        prescale_next = '0;
                        seconds_next  = seconds_inc;
                        // one-shot alarm on stepping onto the match value
                        if (alarm_armed_reg && seconds_inc == match_reg)
                        begin
                            raw_status_next  = 1'b1;
                            alarm_armed_next = 1'b0;
                        end
                    end
                    else
                        prescale_next = prescale_inc;
                end
            end
            default: ;
        endcase
    end

    // Result for the current item
    always_comb
    begin
        result.read_data = (item.operation == rtc_pkg::OP_READ) ? rdata : 32'd0;
        result.irq_level = raw_status_next & irq_mask_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            irq_mask_reg    <= 1'b0;
            raw_status_reg  <= 1'b0;
            alarm_armed_reg <= 1'b0;
            seconds_reg     <= 32'd0;
            load_reg        <= 32'd0;
            match_reg       <= 32'd0;
            prescale_reg    <= '0;
        end
        else if (accept)
        begin
            enabled_reg     <= enabled_next;
            irq_mask_reg    <= irq_mask_next;
            raw_status_reg  <= raw_status_next;
            alarm_armed_reg <= alarm_armed_next;
            seconds_reg     <= seconds_next;
            load_reg        <= load_next;
            match_reg       <= match_next;
            prescale_reg    <= prescale_next;
        end
    end

    `RTC_ASSERT_ALWAYS(a_prescale_range, 32'(prescale_reg) < rtc_pkg::TICKS_PER_SECOND, "prescaler out of range")
    `RTC_ASSERT_ALWAYS(a_prescale_idle, enabled_reg || prescale_reg == '0, "prescaler moved while disabled")
    `RTC_ASSERT_ALWAYS(a_alarm_enabled, !$rose(raw_status_reg) || $past(enabled_reg), "alarm fired while disabled")

endmodule

>>> src/rtc_out_buf.sv
// Two-entry result buffer: keeps the input side open while a result waits.
// Depends on rtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rtc_pkg::out_item_t push_item,
    output logic               can_push,
    rtc_out_if.source          result
);

    rtc_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign can_push     = (count_reg != 2'd2);
    assign result.valid = (count_reg != 2'd0);
    assign result.data  = entry_reg[rd_ptr_reg];
    assign pop          = result.valid && result.ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    `RTC_ASSERT_ALWAYS(a_count_max, count_reg <= 2'd2, "buffer overfilled")
    `RTC_ASSERT_ALWAYS(a_ptr_fill, (wr_ptr_reg ^ rd_ptr_reg) == count_reg[0], "pointers disagree with fill")
    `RTC_ASSERT_NEXT(a_push_only, push && !pop, count_reg == $past(count_reg) + 2'd1, "push lost")

endmodule

>>> src/rtc_seconds_counter_with_alarm.sv
// Top level of the RTC with alarm: register file plus result buffer.
// Depends on rtc_pkg, rtc_in_if, rtc_out_if, rtc_regs and rtc_out_buf.
//
//   channel    dir   payload
//   bus_item   in    operation, reg_offset, write_data, wall_clock_seconds
//   result     out   read_data, irq_level
//
// One item per cycle while bus_item.ready is high; results keep order.
// All register and prescaler updates happen in the accepting cycle.
// A two-entry buffer holds results, so bus_item.ready drops only when two
// results wait untaken. Reset (rst_n low) clears all state asynchronously.
module rtc_seconds_counter_with_alarm (
    input  logic      clk,
    input  logic      rst_n,
    rtc_in_if.sink    bus_item,
    rtc_out_if.source result
);

    logic               accept;
    logic               can_push;
    rtc_pkg::out_item_t step_result;

    assign bus_item.ready = can_push;
    assign accept         = bus_item.valid && can_push;

    rtc_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (bus_item.data),
        .result (step_result)
    );

    rtc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (step_result),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rtc_seconds_counter_with_alarm: directed register and alarm
// arming cases, then random bus traffic, checked against a cycle-free register model.
// Depends on rtc_pkg, rtc_in_if, rtc_out_if and the RTC top level.

// Register model of the RTC plus the queue of results it predicts
class rtc_scoreboard;
    bit          enabled = 1'b0;
    bit          irq_mask = 1'b0;
    bit          raw_status = 1'b0;
    bit          alarm_armed = 1'b0;
    logic [31:0] seconds_count = '0;
    logic [31:0] load_value = '0;
    logic [31:0] match_value = '0;
    int unsigned prescale_count = 0;

    logic [31:0] id_table [8] = '{32'h31, 32'h10, 32'h04, 32'h00,
                                  32'h0d, 32'hf0, 32'h05, 32'hb1};

    rtc_pkg::out_item_t expected_q[$];
    int unsigned mismatches = 0;
    int unsigned items_seen = 0;
    int unsigned results_checked = 0;

    // Apply one accepted item to the register model and queue its result
    function void note_input(rtc_pkg::in_item_t it);
        rtc_pkg::out_item_t want;
        logic [11:0]        ofs;
        logic [31:0]        wd;
        want.read_data = '0;
        ofs = it.reg_offset;
        wd = it.write_data;
        items_seen++;
        case (it.operation)
            rtc_pkg::OP_READ:
            begin
                case (ofs)
                    rtc_pkg::OFS_DATA:   want.read_data = enabled ? seconds_count : 32'd0;
                    rtc_pkg::OFS_MATCH:  want.read_data = match_value;
                    rtc_pkg::OFS_LOAD:   want.read_data = load_value;
                    rtc_pkg::OFS_CTRL:   want.read_data = {31'd0, enabled};
                    rtc_pkg::OFS_MASK:   want.read_data = {31'd0, irq_mask};
                    rtc_pkg::OFS_RAW:    want.read_data = {31'd0, raw_status};
                    rtc_pkg::OFS_MASKED: want.read_data = {31'd0, raw_status & irq_mask};
                    default:
                    begin
                        // ID words: aligned offsets in the top 32 bytes
                        if (ofs >= rtc_pkg::OFS_ID_BASE && ofs[1:0] == 2'b00)
                            want.read_data = id_table[ofs[4:2]];
                    end
                endcase
            end
            rtc_pkg::OP_WRITE:
            begin
                case (ofs)
                    rtc_pkg::OFS_MATCH:
                    begin
                        match_value = wd;
                        alarm_armed = (wd > load_value);
                    end
                    rtc_pkg::OFS_LOAD:
                    begin
                        load_value = wd;
                        seconds_count = wd;
                        prescale_count = 0;
                    end
                    rtc_pkg::OFS_CTRL:
                    begin
                        if (wd[0] != enabled)
                        begin
                            if (wd[0])
                            begin
                                // enable: start from wall time
                                seconds_count = it.wall_clock_seconds;
                                load_value = it.wall_clock_seconds;
                                prescale_count = 0;
                            end
                            else
                            begin
                                // disable: wipe alarm, status, mask and counter
                                raw_status = 1'b0;
                                irq_mask = 1'b0;
                                alarm_armed = 1'b0;
                                match_value = '0;
                                load_value = '0;
                                seconds_count = '0;
                                prescale_count = 0;
                            end
                            enabled = wd[0];
                        end
                    end
                    rtc_pkg::OFS_MASK:  irq_mask = wd[0];
                    rtc_pkg::OFS_CLEAR: if (wd[0]) raw_status = 1'b0;
                    default: ;
                endcase
            end
            rtc_pkg::OP_TICK:
            begin
                // prescaler only runs while enabled
                if (enabled)
                begin
                    prescale_count++;
                    if (prescale_count >= rtc_pkg::TICKS_PER_SECOND)
                    begin
                        prescale_count = 0;
                        seconds_count = seconds_count + 32'd1;
                        if (alarm_armed && seconds_count == match_value)
                        begin
                            raw_status = 1'b1;
                            alarm_armed = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        want.irq_level = raw_status & irq_mask;
        expected_q.push_back(want);
    endfunction

    function void flag(string what, logic [31:0] want_v, logic [31:0] got_v);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
        mismatches++;
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(rtc_pkg::out_item_t got);
        rtc_pkg::out_item_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual read_data %h irq_level %b",
                     $time, got.read_data, got.irq_level);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (got.read_data !== want.read_data)
            flag("read_data", want.read_data, got.read_data);
        if (got.irq_level !== want.irq_level)
            flag("irq_level", {31'd0, want.irq_level}, {31'd0, got.irq_level});
    endfunction
endclass

module tb_top;

    localparam logic [1:0]  OP_NONE      = 2'd3;    // spare code, no effect
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned RANDOM_ITEMS = 600;

    logic clk;
    logic rst_n;

    rtc_in_if  bus_ch();
    rtc_out_if res_ch();

    bit steady = 1'b0;      // no idling on either side while set
    bit hold_req = 1'b0;    // asks the result side for a long hold-off

    rtc_scoreboard sb = new;

    rtc_seconds_counter_with_alarm uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bus_item (bus_ch),
        .result   (res_ch)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one item, with random idle cycles ahead of it, until it is taken
    task automatic send_item(input rtc_pkg::in_item_t it);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            bus_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bus_ch.valid <= 1'b1;
        bus_ch.data <= it;
        @(posedge clk);
        while (!bus_ch.ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic reg_write(input logic [11:0] ofs, input logic [31:0] data,
                             input logic [31:0] wall);
        rtc_pkg::in_item_t it;
        it.operation = rtc_pkg::OP_WRITE;
        it.reg_offset = ofs;
        it.write_data = data;
        it.wall_clock_seconds = wall;
        send_item(it);
    endtask

    task automatic reg_read(input logic [11:0] ofs);
        rtc_pkg::in_item_t it;
        it.operation = rtc_pkg::OP_READ;
        it.reg_offset = ofs;
        it.write_data = $urandom();
        it.wall_clock_seconds = $urandom();
        send_item(it);
    endtask

    // Reference clock ticks with a sprinkling of register reads in between
    task automatic run_ticks(input int unsigned n);
        rtc_pkg::in_item_t it;
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 2)
                reg_read(rtc_pkg::OFS_DATA + 12'(4 * $urandom_range(0, 7)));
            it.operation = rtc_pkg::OP_TICK;
            it.reg_offset = 12'($urandom());
            it.write_data = $urandom();
            it.wall_clock_seconds = $urandom();
            send_item(it);
        end
    endtask

    // Arm an alarm at a random point and run a burst of ticks
    task automatic random_alarm_scenario();
        logic [31:0] start;
        if ($urandom_range(0, 2) == 0)
            start = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
        else
            start = $urandom();
        reg_write(rtc_pkg::OFS_CTRL, 32'h1, $urandom());
        reg_write(rtc_pkg::OFS_LOAD, start, $urandom());
        reg_write(rtc_pkg::OFS_MATCH, start + 32'($urandom_range(1, 2)), $urandom());
        reg_write(rtc_pkg::OFS_MASK, $urandom(), $urandom());
        run_ticks(16 + $urandom_range(0, 40));
        reg_read(rtc_pkg::OFS_RAW);
        reg_read(rtc_pkg::OFS_MASKED);
        reg_read(rtc_pkg::OFS_DATA);
        reg_write(rtc_pkg::OFS_CLEAR, $urandom(), $urandom());
    endtask

    // Random bus item, shaped toward the interesting register values
    function automatic rtc_pkg::in_item_t random_item();
        rtc_pkg::in_item_t it;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        it.write_data = $urandom();
        it.wall_clock_seconds = $urandom();
        if (pick < 38)
            it.operation = rtc_pkg::OP_READ;
        else if (pick < 72)
            it.operation = rtc_pkg::OP_WRITE;
        else if (pick < 98)
            it.operation = rtc_pkg::OP_TICK;
        else
            it.operation = OP_NONE;
        if ($urandom_range(0, 9) < 7)
        begin
            if ($urandom_range(0, 3) == 0)
                it.reg_offset = rtc_pkg::OFS_ID_BASE + 12'(4 * $urandom_range(0, 7));
            else
                it.reg_offset = rtc_pkg::OFS_DATA + 12'(4 * $urandom_range(0, 7));
        end
        else
            it.reg_offset = 12'($urandom());
        if (it.operation == rtc_pkg::OP_WRITE)
        begin
            case (it.reg_offset)
                rtc_pkg::OFS_CTRL:  it.write_data[0] = ($urandom_range(0, 99) < 85);
                rtc_pkg::OFS_MATCH:
                begin
                    // around the load value, to hit both sides of arming
                    if ($urandom_range(0, 1) == 0)
                        it.write_data = sb.load_value + 32'($urandom_range(0, 4)) - 32'd2;
                end
                rtc_pkg::OFS_LOAD:
                begin
                    if ($urandom_range(0, 3) == 0)
                        it.write_data = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h0;
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    // Result side: random back-pressure plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.data);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        rtc_pkg::in_item_t spare;
        rst_n <= 1'b0;
        bus_ch.valid <= 1'b0;
        bus_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register map corners out of reset
        reg_read(rtc_pkg::OFS_DATA);
        reg_read(rtc_pkg::OFS_CTRL);
        run_ticks(1);                                   // tick while disabled
        reg_write(rtc_pkg::OFS_CTRL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        reg_read(rtc_pkg::OFS_DATA);
        reg_read(rtc_pkg::OFS_LOAD);
        reg_write(rtc_pkg::OFS_CTRL, 32'h1, 32'h1234_5678);      // already enabled
        reg_write(rtc_pkg::OFS_MATCH, 32'h0, 32'h0);             // below load: not armed
        reg_write(rtc_pkg::OFS_MATCH, 32'hFFFF_FFFF, 32'h0);     // equal to load: not armed
        reg_write(rtc_pkg::OFS_MASK, 32'hFFFF_FFFF, 32'h0);
        reg_read(rtc_pkg::OFS_MASK);
        reg_write(rtc_pkg::OFS_DATA, 32'hFFFF_FFFF, 32'h0);      // read-only registers
        reg_write(rtc_pkg::OFS_RAW, 32'h1, 32'h0);
        reg_write(rtc_pkg::OFS_MASKED, 32'h1, 32'h0);
        reg_write(rtc_pkg::OFS_ID_BASE, 32'hFFFF_FFFF, 32'h0);
        reg_read(rtc_pkg::OFS_MATCH);
        reg_write(rtc_pkg::OFS_CTRL, 32'hFFFF_FFFE, 32'hFFFF_FFFF);  // disable clears all
        reg_read(rtc_pkg::OFS_MATCH);
        reg_read(rtc_pkg::OFS_MASK);
        reg_read(rtc_pkg::OFS_ID_BASE);
        reg_read(rtc_pkg::OFS_ID_BASE + 12'h01c);
        reg_read(rtc_pkg::OFS_ID_BASE + 12'h002);                // unaligned
        reg_read(12'hfff);
        reg_read(rtc_pkg::OFS_CLEAR + 12'h004);                  // unmapped
        spare.operation = OP_NONE;
        spare.reg_offset = rtc_pkg::OFS_MASK;
        spare.write_data = 32'hFFFF_FFFF;
        spare.wall_clock_seconds = 32'hFFFF_FFFF;
        send_item(spare);
        reg_read(rtc_pkg::OFS_CLEAR);

        // Alarm armed after enable; mask set while disabled survives enable
        reg_write(rtc_pkg::OFS_MASK, 32'h1, 32'h0);
        reg_write(rtc_pkg::OFS_CTRL, 32'h1, 32'h0);
        reg_write(rtc_pkg::OFS_MATCH, 32'h1, 32'h0);
        run_ticks(16);
        reg_read(rtc_pkg::OFS_RAW);
        reg_read(rtc_pkg::OFS_MASKED);
        reg_read(rtc_pkg::OFS_DATA);
        reg_write(rtc_pkg::OFS_CLEAR, 32'hFFFF_FFFE, 32'h0);     // bit 0 low: no clear
        reg_read(rtc_pkg::OFS_RAW);
        reg_write(rtc_pkg::OFS_CLEAR, 32'h1, 32'h0);
        reg_read(rtc_pkg::OFS_RAW);

        // Load near the top count, then ticks part way through a second
        reg_write(rtc_pkg::OFS_LOAD, 32'hFFFF_FFFE, 32'h0);
        reg_write(rtc_pkg::OFS_MATCH, 32'hFFFF_FFFF, 32'h0);
        run_ticks(16);
        reg_write(rtc_pkg::OFS_CLEAR, 32'h1, 32'h0);
        run_ticks(16);
        reg_read(rtc_pkg::OFS_DATA);

        // Load moved past an armed match
        reg_write(rtc_pkg::OFS_LOAD, 32'h0, 32'h0);
        reg_write(rtc_pkg::OFS_MATCH, 32'h1, 32'h0);
        reg_write(rtc_pkg::OFS_LOAD, 32'hFFFF_FFFF, 32'h0);
        run_ticks(16);
        reg_read(rtc_pkg::OFS_RAW);
        run_ticks(16);
        reg_read(rtc_pkg::OFS_RAW);

        // Random traffic with alarm runs, a no-idle stretch and a long result stall
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 300 && i < 460);
            if (i == 100)
                hold_req = 1'b1;
            if (i % 200 == 199)
                random_alarm_scenario();
            send_item(random_item());
        end
        steady = 1'b0;
        bus_ch.valid <= 1'b0;

        // Drain
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run: %0d bus and tick items, %0d results checked.",
                 sb.items_seen, sb.results_checked);
        $display("Covered register map corners, enable/disable, arming, prescaler and back-pressure.");
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #500_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rtc_pkg.sv
src/rtc_in_if.sv
src/rtc_out_if.sv
src/rtc_regs.sv
src/rtc_out_buf.sv
src/rtc_seconds_counter_with_alarm.sv
tb/tb_top.sv
